// File: rtl/sorted_interval_gap_emitter_top_macros.svh
// Assertion macros for the interval gap emitter.
// Used by the sequencer; expects clk and arst_n in scope.
`ifndef SORTED_INTERVAL_GAP_EMITTER_TOP_MACROS_SVH
`define SORTED_INTERVAL_GAP_EMITTER_TOP_MACROS_SVH

// Implication checked at every clock edge outside reset
`define SIGE_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant that holds at every clock edge outside reset
`define SIGE_ASSERT_ALWAYS(name, cond, msg) \
	`SIGE_ASSERT_IMP(name, 1'b1, cond, msg)

`endif

// File: rtl/sige_pkg.sv
// Shared constants, codes and types of the interval gap emitter.
// No dependencies; used by sige_seq and the top level.
package sige_pkg;

	// Table geometry and field widths
	localparam int MAX_CHROMS    = 32;
	localparam int IDX_BITS      = $clog2(MAX_CHROMS);
	localparam int CNT_BITS      = 6;
	localparam int COORD_BITS    = 32;
	localparam int IN_IDX_BITS   = 8;
	localparam int KIND_BITS     = 2;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 6;

	// Input word kinds
	localparam logic [KIND_BITS-1:0] KIND_LOAD     = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_INTERVAL = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_END      = 2'd2;

	// Result status codes
	localparam logic STAT_GAP       = 1'b0;
	localparam logic STAT_ORDER_ERR = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_ONLY_WITH_RECORDS = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CHROM_COUNT       = 1'd1;

	typedef struct packed {
		logic                only_with_records;
		logic [CNT_BITS-1:0] chrom_count;
	} cfg_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]   gap_chrom;
		logic [COORD_BITS-1:0] gap_start;
		logic [COORD_BITS-1:0] gap_end;
		logic                  status;
		logic                  last;
	} res_t;

endpackage

// File: rtl/sige_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the chromosome length table.
module sige_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/sige_seq.sv
// Sequencer of the interval gap emitter: decodes input words, walks the
// length table in sige_ram, and holds the result output register. Uses sige_pkg.
`include "sorted_interval_gap_emitter_top_macros.svh"

module sige_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sige_pkg::cfg_t                     cfg,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sige_pkg::KIND_BITS-1:0]     kind,
	input  logic [sige_pkg::IN_IDX_BITS-1:0]   chrom_index,
	input  logic [sige_pkg::COORD_BITS-1:0]    interval_start,
	input  logic [sige_pkg::COORD_BITS-1:0]    interval_end,
	input  logic [sige_pkg::COORD_BITS-1:0]    chrom_length,
	output logic                               out_valid,
	input  logic                               out_ready,
	output sige_pkg::res_t                     out_res
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TAIL  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_START = 3'd3;
	localparam logic [2:0] S_ERR   = 3'd4;

	localparam int IB = sige_pkg::IDX_BITS;
	localparam int CB = sige_pkg::CNT_BITS;
	localparam int XB = sige_pkg::COORD_BITS;

	logic [2:0]    state_q, state_d;
	logic          is_end_q, is_end_d;
	logic [IB-1:0] idx_q;
	logic [XB-1:0] istart_q, iend_q;
	logic [CB-1:0] stop_q, stop_d;
	logic [CB-1:0] scan_next_q, scan_next_d;
	logic [IB-1:0] open_chrom_q, open_chrom_d;
	logic          open_valid_q, open_valid_d;
	logic [XB-1:0] cursor_q, cursor_d;
	logic [CB-1:0] w_q, w_d;
	logic          out_valid_q;
	sige_pkg::res_t out_q, res_d;
	logic          emit;
	logic          fin;
	logic          accept;

	logic [CB-1:0] eff_count;
	logic          idx_known;
	logic [IB-1:0] in_idx;
	logic          is_open;
	logic          is_err;
	logic          out_free;
	logic          tail_hit;
	logic          walk_need;
	logic          start_gap;
	logic          walk_end;
	logic [CB-1:0] open_next;

	logic          ram_we;
	logic [IB-1:0] ram_raddr;
	logic [XB-1:0] ram_rdata;

	sige_ram #(
		.WIDTH(sige_pkg::COORD_BITS),
		.DEPTH(sige_pkg::MAX_CHROMS)
	) u_len_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(chrom_index[IB-1:0]),
		.wdata(chrom_length),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// decode of the incoming word and of the current walk
	assign eff_count = (cfg.chrom_count > CB'(sige_pkg::MAX_CHROMS)) ?
		CB'(sige_pkg::MAX_CHROMS) : cfg.chrom_count;
	assign idx_known = chrom_index < {{(sige_pkg::IN_IDX_BITS-CB){1'b0}}, eff_count};
	assign in_idx    = chrom_index[IB-1:0];
	assign is_open   = open_valid_q && (in_idx == open_chrom_q);
	assign is_err    = {{(CB-IB){1'b0}}, in_idx} < scan_next_q;
	assign out_free  = !out_valid_q || out_ready;
	assign tail_hit  = open_valid_q && (cursor_q < ram_rdata);
	assign walk_need = !cfg.only_with_records && (scan_next_q < stop_q);
	assign start_gap = !is_end_q && (istart_q != '0);
	assign walk_end  = (w_q == stop_q - 1'b1);
	assign open_next = {{(CB-IB){1'b0}}, open_chrom_q} + 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;

	// next state, result and table access
	always_comb begin
		state_d      = state_q;
		is_end_d     = is_end_q;
		stop_d       = stop_q;
		scan_next_d  = scan_next_q;
		open_chrom_d = open_chrom_q;
		open_valid_d = open_valid_q;
		cursor_d     = cursor_q;
		w_d          = w_q;
		emit         = 1'b0;
		fin          = 1'b0;
		ram_we       = 1'b0;
		res_d        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (kind)
						sige_pkg::KIND_LOAD: begin
							ram_we = (chrom_index < sige_pkg::IN_IDX_BITS'(sige_pkg::MAX_CHROMS));
						end
						sige_pkg::KIND_INTERVAL: begin
							is_end_d = 1'b0;
							if (idx_known) begin
								if (is_open) begin
									if (interval_start != '0) begin
										state_d = S_START;
									end else begin
										cursor_d = interval_end;
									end
								end else if (is_err) begin
									state_d = S_ERR;
								end else begin
									state_d = S_TAIL;
									stop_d  = {{(CB-IB){1'b0}}, in_idx};
								end
							end
						end
						sige_pkg::KIND_END: begin
							is_end_d = 1'b1;
							state_d  = S_TAIL;
							stop_d   = eff_count;
						end
						default: begin
						end
					endcase
				end
			end
			S_TAIL: begin
				if (!tail_hit || out_free) begin
					emit            = tail_hit;
					res_d.gap_chrom = open_chrom_q;
					res_d.gap_start = cursor_q;
					res_d.gap_end   = ram_rdata;
					res_d.status    = sige_pkg::STAT_GAP;
					res_d.last      = !walk_need && !start_gap;
					cursor_d        = '0;
					if (walk_need) begin
						state_d = S_WALK;
						w_d     = scan_next_q;
					end else begin
						fin = 1'b1;
					end
				end
			end
			S_WALK: begin
				if (out_free) begin
					emit            = 1'b1;
					res_d.gap_chrom = w_q[IB-1:0];
					res_d.gap_start = '0;
					res_d.gap_end   = ram_rdata;
					res_d.status    = sige_pkg::STAT_GAP;
					res_d.last      = walk_end && !start_gap;
					if (walk_end) begin
						fin = 1'b1;
					end else begin
						w_d = w_q + 1'b1;
					end
				end
			end
			S_START: begin
				if (out_free) begin
					emit            = 1'b1;
					res_d.gap_chrom = idx_q;
					res_d.gap_start = cursor_q;
					res_d.gap_end   = istart_q;
					res_d.status    = sige_pkg::STAT_GAP;
					res_d.last      = 1'b1;
					state_d         = S_IDLE;
					scan_next_d     = {{(CB-IB){1'b0}}, idx_q} + 1'b1;
					open_chrom_d    = idx_q;
					open_valid_d    = 1'b1;
					cursor_d        = iend_q;
				end
			end
			S_ERR: begin
				if (out_free) begin
					emit            = 1'b1;
					res_d.gap_chrom = idx_q;
					res_d.status    = sige_pkg::STAT_ORDER_ERR;
					res_d.last      = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// end of tail and walk: close the pass, go on to the leading gap, or open the new chromosome
		if (fin) begin
			if (is_end_q) begin
				state_d      = S_IDLE;
				scan_next_d  = '0;
				open_chrom_d = '0;
				open_valid_d = 1'b0;
				cursor_d     = '0;
			end else if (start_gap) begin
				state_d = S_START;
			end else begin
				state_d      = S_IDLE;
				scan_next_d  = {{(CB-IB){1'b0}}, idx_q} + 1'b1;
				open_chrom_d = idx_q;
				open_valid_d = 1'b1;
				cursor_d     = iend_q;
			end
		end
	end

	// read the entry that the next cycle works on
	assign ram_raddr = (state_d == S_TAIL) ? open_chrom_q : w_d[IB-1:0];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			is_end_q     <= 1'b0;
			stop_q       <= '0;
			scan_next_q  <= '0;
			open_chrom_q <= '0;
			open_valid_q <= 1'b0;
			cursor_q     <= '0;
			w_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			is_end_q     <= is_end_d;
			stop_q       <= stop_d;
			scan_next_q  <= scan_next_d;
			open_chrom_q <= open_chrom_d;
			open_valid_q <= open_valid_d;
			cursor_q     <= cursor_d;
			w_q          <= w_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// captured input word and output word
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q    <= in_idx;
			istart_q <= interval_start;
			iend_q   <= interval_end;
		end
		if (emit) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	`SIGE_ASSERT_ALWAYS(a_scan_range, scan_next_q <= CB'(sige_pkg::MAX_CHROMS), "scan index past table")
	`SIGE_ASSERT_ALWAYS(a_open_scan, !open_valid_q || (scan_next_q == open_next), "scan index not after open chromosome")
	`SIGE_ASSERT_IMP(a_walk_range, state_q == S_WALK, w_q < stop_q, "walk index past stop")
	`SIGE_ASSERT_IMP(a_err_last, out_valid_q && (out_q.status == sige_pkg::STAT_ORDER_ERR), out_q.last, "order error word not last")

endmodule

// File: rtl/sorted_interval_gap_emitter_top.sv
// Top level of the sorted interval gap emitter: configuration registers,
// sequencer and port breakout. Depends on sige_pkg, sige_seq and sige_ram.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | kind, chrom_index, interval_start, interval_end, chrom_length
//  out     | out_valid / out_ready| gap_chrom, gap_start, gap_end, status, last
//  cfg     | cfg_wr_en            | cfg_index, cfg_wdata
//
// Load words and intervals on the open chromosome without a leading gap are handled in the idle state;
// an interval with a leading gap on the open chromosome passes through the start state.
// A chromosome switch or end word passes through the tail state, then the walk state for each walked
// table entry and the start state for a leading gap, as the length table has a single read port.
// No clearing pass after reset; the length table must be loaded before use.
// A stalled output word holds the sequencer in place; input is taken only when idle.
module sorted_interval_gap_emitter_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [sige_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [sige_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [sige_pkg::KIND_BITS-1:0]       kind,
	input  logic [sige_pkg::IN_IDX_BITS-1:0]     chrom_index,
	input  logic [sige_pkg::COORD_BITS-1:0]      interval_start,
	input  logic [sige_pkg::COORD_BITS-1:0]      interval_end,
	input  logic [sige_pkg::COORD_BITS-1:0]      chrom_length,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sige_pkg::IDX_BITS-1:0]        gap_chrom,
	output logic [sige_pkg::COORD_BITS-1:0]      gap_start,
	output logic [sige_pkg::COORD_BITS-1:0]      gap_end,
	output logic                                 status,
	output logic                                 last
);

	sige_pkg::cfg_t cfg_q;
	sige_pkg::res_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sige_pkg::CFG_ONLY_WITH_RECORDS: cfg_q.only_with_records <= cfg_wdata[0];
				sige_pkg::CFG_CHROM_COUNT:       cfg_q.chrom_count <= cfg_wdata[sige_pkg::CNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	sige_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.chrom_index   (chrom_index),
		.interval_start(interval_start),
		.interval_end  (interval_end),
		.chrom_length  (chrom_length),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_res       (res)
	);

	// result word to ports
	assign gap_chrom = res.gap_chrom;
	assign gap_start = res.gap_start;
	assign gap_end   = res.gap_end;
	assign status    = res.status;
	assign last      = res.last;

endmodule
